/* sv/sii_pkg.sv */
// Shared types and constants of the secondary index unit.
// No dependencies.
package sii_pkg;

  localparam int KEY_ENTRIES_DEF   = 256;
  localparam int LABEL_ENTRIES_DEF = 1024;
  localparam int MAX_IDS_OUT_DEF   = 64;
  localparam int QUEUE_DEPTH       = 2;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_SEARCH = 2'd2
  } kind_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_TRUNC     = 2'd3;

  typedef struct packed {
    kind_t        kind;
    logic [63:0]  key;
    logic [31:0]  id;
  } req_t;

  typedef enum logic [3:0] {
    S_IDLE, S_BS_CHK, S_BS_CMP, S_LOOK, S_INS_RD, S_INS_WR,
    S_RM_RD, S_RM_CHK, S_DEL_RD, S_DEL_WR, S_SR_RD, S_SR_OUT
  } state_t;

endpackage

/* sv/secondary_index_inverted_lists_unit.sv */
// Top level of the secondary index unit: request queue plus execution engine.
// Depends on sii_pkg, sii_front, sii_back.
//
//  channel   handshake         ports
//  request   start & !busy     kind, key, record_id
//  result    valid strobe      found_id, status, last
//
// A lookup is a binary search, each step one read of the key memory port.
// Adding a new key shifts the table up, one entry per read and write;
// removing walks the list label by label, and an emptied key shifts the
// table down. A search streams one id per list label read.
// Reset clears the key and label counts; no clearing pass. Results cannot
// be stalled; the two-entry request queue lets start be taken meanwhile.
module secondary_index_inverted_lists_unit import sii_pkg::*; #(
  parameter int KEY_ENTRIES   = KEY_ENTRIES_DEF,
  parameter int LABEL_ENTRIES = LABEL_ENTRIES_DEF,
  parameter int MAX_IDS_OUT   = MAX_IDS_OUT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [63:0] key,
  input  logic [31:0] record_id,
  output logic        valid,
  output logic [31:0] found_id,
  output logic [1:0]  status,
  output logic        last
);

  logic q_valid, q_pop;
  req_t q_req;

  sii_front u_front (
    .clk, .rst, .start, .busy, .kind, .key, .record_id,
    .q_valid, .q_req, .q_pop
  );

  sii_back #(
    .KEY_ENTRIES  (KEY_ENTRIES),
    .LABEL_ENTRIES(LABEL_ENTRIES),
    .MAX_IDS_OUT  (MAX_IDS_OUT)
  ) u_back (
    .clk, .rst, .q_valid, .q_req, .q_pop,
    .valid, .found_id, .status, .last
  );

endmodule

/* sv/sii_front.sv */
// Front end: accepts requests, drops unused kinds, queues the rest.
// Depends on sii_pkg.
module sii_front import sii_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [63:0] key,
  input  logic [31:0] record_id,
  output logic        q_valid,
  output req_t        q_req,
  input  logic        q_pop
);

  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  req_t            slots [QUEUE_DEPTH];
  logic [QW-1:0]   wptr, rptr;
  logic [QW:0]     count;
  logic            legal, push, pop;

  always_comb begin
    unique case (kind)
      KIND_ADD, KIND_REMOVE, KIND_SEARCH: legal = 1'b1;
      default: legal = 1'b0;
    endcase
  end

  assign busy    = (count == (QW+1)'(QUEUE_DEPTH));
  assign push    = start && !busy && legal;
  assign q_valid = (count != '0);
  assign pop     = q_pop && q_valid;
  assign q_req   = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= '{kind: kind_t'(kind), key: key, id: record_id};
    end
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == QW'(QUEUE_DEPTH-1)) ? '0 : wptr + 1'b1;
      if (pop)  rptr <= (rptr == QW'(QUEUE_DEPTH-1)) ? '0 : rptr + 1'b1;
      count <= count + (QW+1)'(push) - (QW+1)'(pop);
    end
  end

endmodule

/* sv/sii_back.sv */
// Back end: binary search, sorted table shifts and list walks over the stores.
// Depends on sii_pkg.
module sii_back import sii_pkg::*; #(
  parameter int KEY_ENTRIES   = KEY_ENTRIES_DEF,
  parameter int LABEL_ENTRIES = LABEL_ENTRIES_DEF,
  parameter int MAX_IDS_OUT   = MAX_IDS_OUT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  req_t        q_req,
  output logic        q_pop,
  output logic        valid,
  output logic [31:0] found_id,
  output logic [1:0]  status,
  output logic        last
);

  localparam int KW  = $clog2(KEY_ENTRIES);
  localparam int LW  = $clog2(LABEL_ENTRIES);
  localparam int CW  = KW + 1;
  localparam int LCW = LW + 1;
  localparam int NW  = $clog2(MAX_IDS_OUT + 1);
  localparam logic [LCW-1:0] LIST_END = LCW'(LABEL_ENTRIES);

  logic [63:0]    key_mem  [KEY_ENTRIES];
  logic [LW-1:0]  head_mem [KEY_ENTRIES];
  logic [31:0]    id_mem   [LABEL_ENTRIES];
  logic [LCW-1:0] next_mem [LABEL_ENTRIES];

  state_t         state, state_next;
  kind_t          op, op_next;
  logic [63:0]    key_r, key_r_next;
  logic [31:0]    id_r, id_r_next;
  logic [CW-1:0]  lo, lo_next, hi, hi_next, count, count_next, j, j_next;
  logic [LCW-1:0] lc, lc_next, cur, cur_next, prv, prv_next, steps, steps_next;
  logic [NW-1:0]  n, n_next;
  logic           valid_next, last_next;
  logic [31:0]    found_id_next;
  logic [1:0]     status_next;

  logic [KW-1:0]  kra, kwa;
  logic           kwe, hwe;
  logic [63:0]    kwd, kq;
  logic [LW-1:0]  hwd, hq;
  logic [LW-1:0]  lra, iwa, nwa;
  logic           iwe, nwe;
  logic [31:0]    iwd, idq;
  logic [LCW-1:0] nwd, nq;

  logic [CW:0]    mid_w;
  logic [KW-1:0]  mid;
  logic           hit;

  assign mid_w = ({1'b0, lo} + {1'b0, hi}) >> 1;
  assign mid   = mid_w[KW-1:0];
  assign hit   = (lo < count) && (kq == key_r);

  always_ff @(posedge clk) begin
    if (kwe) key_mem[kwa] <= kwd;
    if (hwe) head_mem[kwa] <= hwd;
    kq <= key_mem[kra];
    hq <= head_mem[kra];
    if (iwe) id_mem[iwa] <= iwd;
    if (nwe) next_mem[nwa] <= nwd;
    idq <= id_mem[lra];
    nq  <= next_mem[lra];
  end

  always_comb begin
    state_next    = state;
    op_next       = op;
    key_r_next    = key_r;
    id_r_next     = id_r;
    lo_next       = lo;
    hi_next       = hi;
    count_next    = count;
    j_next        = j;
    lc_next       = lc;
    cur_next      = cur;
    prv_next      = prv;
    steps_next    = steps;
    n_next        = n;
    valid_next    = 1'b0;
    found_id_next = '0;
    status_next   = ST_OK;
    last_next     = 1'b1;
    q_pop         = 1'b0;
    kra = mid;
    kwa = lo[KW-1:0];
    kwe = 1'b0;
    hwe = 1'b0;
    kwd = key_r;
    hwd = lc[LW-1:0] - 1'b1;
    lra = cur[LW-1:0];
    iwa = lc[LW-1:0];
    nwa = lc[LW-1:0];
    iwe = 1'b0;
    nwe = 1'b0;
    iwd = id_r;
    nwd = LIST_END;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          op_next    = q_req.kind;
          key_r_next = q_req.key;
          id_r_next  = q_req.id;
          lo_next    = '0;
          hi_next    = count;
          state_next = S_BS_CHK;
        end
      end
      S_BS_CHK: begin
        if (lo < hi) begin
          kra        = mid;
          state_next = S_BS_CMP;
        end else begin
          kra        = lo[KW-1:0];
          state_next = S_LOOK;
        end
      end
      S_BS_CMP: begin
        if (kq < key_r) lo_next = CW'(mid) + 1'b1;
        else hi_next = CW'(mid);
        state_next = S_BS_CHK;
      end
      S_LOOK: begin
        unique case (op)
          KIND_ADD: begin
            if (lc >= LIST_END || (!hit && count >= CW'(KEY_ENTRIES))) begin
              valid_next  = 1'b1;
              status_next = ST_FULL;
              state_next  = S_IDLE;
            end else begin
              iwe     = 1'b1;
              lc_next = lc + 1'b1;
              if (hit) begin
                nwe         = 1'b1;
                nwd         = {1'b0, hq};
                hwe         = 1'b1;
                hwd         = lc[LW-1:0];
                valid_next  = 1'b1;
                state_next  = S_IDLE;
              end else begin
                nwe        = 1'b1;
                nwd        = LIST_END;
                j_next     = count;
                state_next = S_INS_RD;
              end
            end
          end
          KIND_REMOVE: begin
            if (!hit) begin
              valid_next  = 1'b1;
              status_next = ST_NOT_FOUND;
              state_next  = S_IDLE;
            end else begin
              cur_next   = {1'b0, hq};
              prv_next   = LIST_END;
              steps_next = '0;
              state_next = S_RM_RD;
            end
          end
          default: begin
            if (!hit) begin
              valid_next  = 1'b1;
              status_next = ST_NOT_FOUND;
              state_next  = S_IDLE;
            end else begin
              cur_next   = {1'b0, hq};
              n_next     = '0;
              state_next = S_SR_RD;
            end
          end
        endcase
      end
      S_INS_RD: begin
        if (j > lo) begin
          kra        = KW'(j - 1'b1);
          state_next = S_INS_WR;
        end else begin
          kwa        = lo[KW-1:0];
          kwe        = 1'b1;
          hwe        = 1'b1;
          kwd        = key_r;
          hwd        = lc[LW-1:0] - 1'b1;
          count_next = count + 1'b1;
          valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_INS_WR: begin
        kwa        = j[KW-1:0];
        kwe        = 1'b1;
        hwe        = 1'b1;
        kwd        = kq;
        hwd        = hq;
        j_next     = j - 1'b1;
        state_next = S_INS_RD;
      end
      S_RM_RD: begin
        if (cur < lc && steps < LIST_END) begin
          lra        = cur[LW-1:0];
          state_next = S_RM_CHK;
        end else begin
          valid_next  = 1'b1;
          status_next = ST_NOT_FOUND;
          state_next  = S_IDLE;
        end
      end
      S_RM_CHK: begin
        if (idq == id_r) begin
          if (prv == LIST_END) begin
            if (nq >= lc) begin
              j_next     = lo;
              state_next = S_DEL_RD;
            end else begin
              kwa        = lo[KW-1:0];
              hwe        = 1'b1;
              hwd        = nq[LW-1:0];
              valid_next = 1'b1;
              state_next = S_IDLE;
            end
          end else begin
            nwa        = prv[LW-1:0];
            nwe        = 1'b1;
            nwd        = nq;
            valid_next = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          prv_next   = cur;
          cur_next   = nq;
          steps_next = steps + 1'b1;
          state_next = S_RM_RD;
        end
      end
      S_DEL_RD: begin
        if (j + 1'b1 < count) begin
          kra        = KW'(j + 1'b1);
          state_next = S_DEL_WR;
        end else begin
          count_next = count - 1'b1;
          valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DEL_WR: begin
        kwa        = j[KW-1:0];
        kwe        = 1'b1;
        hwe        = 1'b1;
        kwd        = kq;
        hwd        = hq;
        j_next     = j + 1'b1;
        state_next = S_DEL_RD;
      end
      S_SR_RD: begin
        if (cur < lc) begin
          lra        = cur[LW-1:0];
          state_next = S_SR_OUT;
        end else begin
          valid_next  = 1'b1;
          status_next = ST_NOT_FOUND;
          state_next  = S_IDLE;
        end
      end
      S_SR_OUT: begin
        valid_next    = 1'b1;
        found_id_next = idq;
        if (n + 1'b1 == NW'(MAX_IDS_OUT) || nq >= lc) begin
          status_next = (nq < lc) ? ST_TRUNC : ST_OK;
          state_next  = S_IDLE;
        end else begin
          last_next  = 1'b0;
          cur_next   = nq;
          n_next     = n + 1'b1;
          state_next = S_SR_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    op       <= op_next;
    key_r    <= key_r_next;
    id_r     <= id_r_next;
    lo       <= lo_next;
    hi       <= hi_next;
    j        <= j_next;
    cur      <= cur_next;
    prv      <= prv_next;
    steps    <= steps_next;
    n        <= n_next;
    found_id <= found_id_next;
    status   <= status_next;
    last     <= last_next;
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      lc    <= '0;
      valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      lc    <= lc_next;
      valid <= valid_next;
    end
  end

endmodule
